>>> rtl/core/sbt_pkg.sv
// Shared types and constants for the sorted breakpoint table.
`timescale 1ns / 1ps

package sbt_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int ADDR_W = 20;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_CHECK  = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LIST
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic [ADDR_W-1:0]   addr;
   } cell_ctrl_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   address;
   } req_type;

   typedef struct packed {
      logic                status;
      logic                hit;
      logic [ADDR_W-1:0]   entry_address;
      logic                entry_valid;
      logic                last;
   } rsp_type;

endpackage

>>> rtl/core/sbt_cell.sv
// One cell of the breakpoint chain: holds a single entry and trades it with its neighbors.
`timescale 1ns / 1ps

module sbt_cell import sbt_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [CNT_W-1:0]    count,
   input  logic [ADDR_W-1:0]   left_entry,
   input  logic                left_gt,
   input  logic [ADDR_W-1:0]   right_entry,
   input  logic [ADDR_W-1:0]   head_entry,
   output logic [ADDR_W-1:0]   entry,
   output logic                gt,
   output logic                match
);

   logic [ADDR_W-1:0] entry_ff;
   logic [ADDR_W-1:0] entry_in;
   logic              valid;
   logic              tail;

   assign valid = CNT_W'(INDEX) < count;
   assign tail  = count == CNT_W'(INDEX + 1);
   assign gt    = valid && (entry_ff > ctrl.addr);
   assign match = valid && (entry_ff == ctrl.addr);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         CELL_INSERT: begin
            if (left_gt) begin
               entry_in = left_entry;
            end else if (!valid || gt) begin
               entry_in = ctrl.addr;
            end
         end
         CELL_ROTATE: begin
            if (tail) begin
               entry_in = head_entry;
            end else if (valid) begin
               entry_in = right_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/core/sbt_array.sv
// Row of breakpoint cells wired to their neighbors.
`timescale 1ns / 1ps

module sbt_array import sbt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [CNT_W-1:0]      count,
   output logic [ADDR_W-1:0]     head_entry,
   output logic [CAPACITY-1:0]   match
);

   logic [ADDR_W-1:0] entry_w [CAPACITY];
   logic              gt_w    [CAPACITY];

   assign head_entry = entry_w[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ADDR_W-1:0] left_entry;
      logic              left_gt;
      logic [ADDR_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_gt    = 1'b0;
      end else begin : g_inner
         assign left_entry = entry_w[i-1];
         assign left_gt    = gt_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_entry = entry_w[i];
      end else begin : g_mid
         assign right_entry = entry_w[i+1];
      end

      sbt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .head_entry  (entry_w[0]),
         .entry       (entry_w[i]),
         .gt          (gt_w[i]),
         .match       (match[i])
      );
   end

endmodule

>>> rtl/core/sorted_breakpoint_table_unit.sv
// Top level of the sorted breakpoint table: command sequencer, result register and cell row.
//
// Items arrive on the req_ channel as an operation and an address; results leave on
// the rsp_ channel, each with a last mark on the final result of its item.
// Insert, clear and list of an empty table give their one result in the register in the
// cycle after the item is taken. Insert shifts the cells above the sorted position up
// by one in that same cycle; a full table drops the insert and reports status full.
// Check registers the per-cell compare vector and reduces it into the result register
// from the check state. List rotates the occupied cells toward cell zero, one entry
// per cycle while the receiver takes results, and emits cell zero with each rotation;
// after count rotations the order is back.
// A new item is taken once the sequencer is idle and the result register is empty
// or being emptied in the same cycle.
// When the receiver stalls, the result register holds its item and the sequencer waits.
// Reset clears the entry count, the sequencer and the result valid; stored addresses
// are not cleared and are never read above the count.
`timescale 1ns / 1ps

module sorted_breakpoint_table_unit import sbt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [CAPACITY-1:0] match_ff, match_in;

   logic                rsp_free;
   logic                accept;
   logic                full;
   logic                list_last;
   logic                rsp_load;
   rsp_type             rsp_next;
   logic                match_load;
   cell_ctrl_type       ctrl;
   logic [ADDR_W-1:0]   head_entry;
   logic [CAPACITY-1:0] match;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign list_last = CNT_W'(idx_ff + 1'b1) == count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_CHECK) begin
                  state_in = ST_CHECK;
               end else if (req_data.op == OP_LIST && count_ff != '0) begin
                  state_in = ST_LIST;
               end
            end
         end
         ST_CHECK: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (rsp_free && list_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctrl.cmd   = CELL_HOLD;
      ctrl.addr  = req_data.address;
      rsp_load   = 1'b0;
      rsp_next   = '0;
      count_in   = count_ff;
      idx_in     = idx_ff;
      match_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = rsp_free;
            if (req_valid && rsp_free) begin
               case (req_data.op)
                  OP_INSERT: begin
                     rsp_load      = 1'b1;
                     rsp_next.last = 1'b1;
                     if (full) begin
                        rsp_next.status = 1'b1;
                     end else begin
                        ctrl.cmd = CELL_INSERT;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  OP_CLEAR: begin
                     rsp_load      = 1'b1;
                     rsp_next.last = 1'b1;
                     count_in      = '0;
                  end
                  OP_CHECK: begin
                     match_load = 1'b1;
                  end
                  OP_LIST: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_next.last = 1'b1;
                     end
                  end
                  default: rsp_load = 1'b0;
               endcase
            end
         end
         ST_CHECK: begin
            if (rsp_free) begin
               rsp_load      = 1'b1;
               rsp_next.hit  = |match_ff;
               rsp_next.last = 1'b1;
            end
         end
         ST_LIST: begin
            if (rsp_free) begin
               rsp_load               = 1'b1;
               rsp_next.entry_address = head_entry;
               rsp_next.entry_valid   = 1'b1;
               rsp_next.last          = list_last;
               ctrl.cmd               = CELL_ROTATE;
               idx_in                 = CNT_W'(idx_ff + 1'b1);
            end
         end
         default: req_ready = 1'b0;
      endcase
   end

   assign match_in     = match_load ? match : match_ff;
   assign rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      match_ff    <= match_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sbt_array #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_array (
      .clock      (clock),
      .ctrl       (ctrl),
      .count      (count_ff),
      .head_entry (head_entry),
      .match      (match)
   );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the sorted breakpoint table with randomized handshakes.
`timescale 1ns / 1ps

module testbench;
   import sbt_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEFAULT;
   localparam int ITEM_TARGET = 230;
   localparam logic [ADDR_W-1:0] ADDR_TOP = 20'hFFFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type           command_queue[$];
   rsp_type           table_replies[$];
   logic [ADDR_W-1:0] shadow_entries[TABLE_DEPTH];
   int                shadow_count = 0;
   int                mismatch_count = 0;
   logic              req_taken = 1'b0;
   int                req_gap = 0;
   int                rsp_stall = 0;
   int                req_idle_pct = 20;
   int                rsp_idle_pct = 20;
   int                phase_cycles = 0;

   sorted_breakpoint_table_unit #(.CAPACITY(TABLE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 3);
      end else if (roll < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic int pick_idle_pct();
      int roll;
      roll = $urandom_range(0, 3);
      if (roll == 0) begin
         return 0;
      end else if (roll == 3) begin
         return 50;
      end
      return 20;
   endfunction

   function automatic logic [ADDR_W-1:0] draw_address();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         return ($urandom_range(0, 1) == 0) ? '0 : ADDR_TOP;
      end else if (roll < 30) begin
         return ADDR_W'($urandom_range(0, 15));
      end else if (roll < 40) begin
         return ADDR_TOP - ADDR_W'($urandom_range(0, 15));
      end
      return ADDR_W'($urandom);
   endfunction

   task automatic queue_command(op_type op, logic [ADDR_W-1:0] address);
      req_type item;
      item.op = op;
      item.address = address;
      command_queue.push_back(item);
   endtask

   // Applies one command to the shadow table and records the replies it must produce.
   task automatic table_command(req_type cmd);
      rsp_type reply;
      int      pos;
      reply = '0;
      reply.last = 1'b1;
      case (cmd.op)
         OP_INSERT: begin
            if (shadow_count >= TABLE_DEPTH) begin
               reply.status = 1'b1;
            end else begin
               pos = shadow_count;
               for (int i = 0; i < shadow_count; i++) begin
                  if (shadow_entries[i] > cmd.address) begin
                     pos = i;
                     break;
                  end
               end
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_entries[i] = shadow_entries[i - 1];
               end
               shadow_entries[pos] = cmd.address;
               shadow_count++;
            end
            table_replies.push_back(reply);
         end
         OP_CLEAR: begin
            shadow_count = 0;
            table_replies.push_back(reply);
         end
         OP_CHECK: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_entries[i] == cmd.address) begin
                  reply.hit = 1'b1;
               end
            end
            table_replies.push_back(reply);
         end
         default: begin
            if (shadow_count == 0) begin
               table_replies.push_back(reply);
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  reply.entry_address = shadow_entries[i];
                  reply.entry_valid = 1'b1;
                  reply.last = (i == shadow_count - 1);
                  table_replies.push_back(reply);
               end
            end
         end
      endcase
   endtask

   task automatic compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            table_command(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (table_replies.size() == 0) begin
               $display("%0t mismatch: item with no pending reply, actual %0h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = table_replies.pop_front();
               compare_field("status", ADDR_W'(want.status), ADDR_W'(rsp_data.status));
               compare_field("hit", ADDR_W'(want.hit), ADDR_W'(rsp_data.hit));
               compare_field("entry_address", want.entry_address, rsp_data.entry_address);
               compare_field("entry_valid", ADDR_W'(want.entry_valid),
                             ADDR_W'(rsp_data.entry_valid));
               compare_field("last", ADDR_W'(want.last), ADDR_W'(rsp_data.last));
            end
         end
      end
   end

   always @(negedge clock) begin
      phase_cycles <= phase_cycles + 1;
      if (phase_cycles % 48 == 0) begin
         req_idle_pct <= pick_idle_pct();
         rsp_idle_pct <= pick_idle_pct();
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (command_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= command_queue.pop_front();
            if ($urandom_range(0, 99) < req_idle_pct) begin
               req_gap <= draw_gap();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_stall <= draw_gap();
         end
      end
   end

   initial begin
      logic [ADDR_W-1:0] placed[$];
      logic [ADDR_W-1:0] pick;
      int                insert_goal;
      int                inserted;
      int                roll;

      // Empty table, extremes, duplicates, fill to capacity, overflow and clear.
      queue_command(OP_LIST, '0);
      queue_command(OP_CHECK, '0);
      queue_command(OP_INSERT, ADDR_TOP);
      queue_command(OP_INSERT, '0);
      queue_command(OP_INSERT, 20'h80000);
      queue_command(OP_INSERT, 20'h80000);
      queue_command(OP_CHECK, 20'h80000);
      queue_command(OP_CHECK, 20'h7FFFF);
      queue_command(OP_LIST, ADDR_TOP);
      for (int i = 0; i < TABLE_DEPTH - 4; i++) begin
         queue_command(OP_INSERT, draw_address());
      end
      queue_command(OP_INSERT, 20'h55555);
      queue_command(OP_LIST, 20'hAAAAA);
      queue_command(OP_CHECK, ADDR_TOP);
      queue_command(OP_CLEAR, ADDR_TOP);
      queue_command(OP_LIST, '0);
      queue_command(OP_CHECK, ADDR_TOP);

      // Random rounds: a burst of inserts mixed with checks, lists and rare clears, then a list and usually a clear.
      while (command_queue.size() < ITEM_TARGET) begin
         insert_goal = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 20)
                                                   : $urandom_range(0, 14);
         inserted = 0;
         while (inserted < insert_goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               pick = (placed.size() != 0 && $urandom_range(0, 3) == 0)
                      ? placed[$urandom_range(0, placed.size() - 1)] : draw_address();
               queue_command(OP_INSERT, pick);
               placed.push_back(pick);
               inserted++;
            end else if (roll < 80) begin
               pick = (placed.size() != 0 && $urandom_range(0, 1) == 0)
                      ? placed[$urandom_range(0, placed.size() - 1)] : draw_address();
               queue_command(OP_CHECK, pick);
            end else if (roll < 97) begin
               queue_command(OP_LIST, ADDR_W'($urandom));
            end else begin
               queue_command(OP_CLEAR, ADDR_W'($urandom));
               placed.delete();
            end
         end
         queue_command(OP_LIST, ADDR_W'($urandom));
         if ($urandom_range(0, 9) != 0) begin
            queue_command(OP_CLEAR, ADDR_W'($urandom));
            placed.delete();
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (command_queue.size() != 0 || req_valid) @(negedge clock);
      while (table_replies.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      if (mismatch_count == 0 && table_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
